FILE: src/ier_pkg.sv
// ier_pkg: command and status bundles shared by the echo responder controller and datapath
// no dependencies
`default_nettype none

package ier_pkg;

	// commands from the controller to the datapath
	typedef struct packed {
		logic store;     // merge the accepted input word into the packet store
		logic flush;     // write the partly filled word to the store
		logic clr_pass;  // restart the word counter and clear the checksum sums
		logic rd_en;     // read the store at the word counter and step it
		logic rd_sum;    // the read belongs to the checksum pass
		logic fold;      // fold the sums into the two checksums
		logic load_out;  // load the output register from the read data
		logic end_pkt;   // packet finished: clear byte count and overflow flag
	} ier_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic pre_ok;     // stored header passes the version, length and protocol checks
		logic pass_end;   // the word counter points at the last word of the reply
		logic type_ok;    // the icmp type is an echo request
		logic out_taken;  // the output word is taken this cycle
		logic out_last;   // the output word held is the last of the reply
	} ier_stat_t;

endpackage

`default_nettype wire

FILE: src/ier_datapath.sv
// ier_datapath: packet store, byte packing, header checks, checksum sums and reply output register
// depends on ier_pkg
`default_nettype none

module ier_datapath #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [63:0]       in_word,
	input  wire logic [3:0]        in_byte_count,
	input  wire ier_pkg::ier_cmd_t cmd,
	output ier_pkg::ier_stat_t     stat,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [63:0]            out_word,
	output logic [3:0]             out_byte_count,
	output logic                   out_last
);
	import ier_pkg::*;

	localparam int DEPTH = (MAX_PACKET_BYTES + 7) / 8;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 4;
	localparam int SW    = AW + 18;
	localparam logic [CW-1:0] MAX_BYTES = CW'(MAX_PACKET_BYTES);
	localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);

	localparam logic [3:0]  IP_VERSION_4   = 4'd4;
	localparam logic [3:0]  MIN_IHL        = 4'd5;
	localparam logic [15:0] MIN_HDR_BYTES  = 16'd20;
	localparam logic [7:0]  PROTO_ICMP     = 8'd1;
	localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
	localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
	localparam logic [15:0] IP_CSUM_HI     = 16'd10;
	localparam logic [15:0] IP_CSUM_LO     = 16'd11;

	// top n bytes of a word set
	function automatic logic [63:0] top_mask(input logic [3:0] n);
		logic [63:0] m;
		m = '0;
		for (int j = 0; j < 8; j++) begin
			if (4'(j) < n) begin
				m[63 - 8 * j -: 8] = 8'hFF;
			end
		end
		return m;
	endfunction

	// end-around carry fold and complement
	function automatic logic [15:0] fold_csum(input logic [SW-1:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = 17'(s[15:0]) + 17'(s[SW-1:16]);
		b = 17'(a[15:0]) + 17'(a[16]);
		return ~b[15:0];
	endfunction

	logic [63:0]   pkt_mem_q [DEPTH];
	logic [CW-1:0] br_q;
	logic          ov_q;
	logic [63:0]   acc_q;
	logic [63:0]   hdr0_q, hdr1_q, hdr2_q;
	logic [63:0]   rdata_s1;
	logic [AW-1:0] addr_s1;
	logic          rvld_s1;
	logic          sum_s1;
	logic [AW-1:0] wcnt_q;
	logic [SW-1:0] ip_acc_q, icmp_acc_q;
	logic [7:0]    type_q;
	logic [15:0]   ip_csum_q, icmp_csum_q;
	logic          out_valid_q;
	logic [63:0]   out_word_q;
	logic [3:0]    out_cnt_q;
	logic          out_last_q;

	// byte packing of the incoming word
	logic [3:0]    cnt_c;
	logic [CW-1:0] room;
	logic [3:0]    eff;
	logic          ovf_now;
	logic [2:0]    r;
	logic [63:0]   word_m;
	logic [63:0]   combined;
	logic [63:0]   remainder;
	logic          spill;
	logic [AW:0]   wr_addr_w;
	logic          wen;
	logic [63:0]   wdata;

	always_comb begin
		cnt_c = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
		room  = MAX_BYTES - br_q;
		if (CW'(cnt_c) > room) begin
			eff     = room[3:0];
			ovf_now = 1'b1;
		end else begin
			eff     = cnt_c;
			ovf_now = 1'b0;
		end
		r         = br_q[2:0];
		word_m    = in_word & top_mask(eff);
		combined  = (acc_q & top_mask({1'b0, r})) | (word_m >> {r, 3'b000});
		remainder = word_m << (7'd64 - {1'b0, r, 3'b000});
		spill     = ({1'b0, r} + eff) >= 4'd8;
		wr_addr_w = br_q[CW-1:3];
		wen       = (cmd.store || (cmd.flush && r != 3'd0)) && (wr_addr_w < DEPTH_W);
		wdata     = cmd.store ? combined : acc_q;
	end

	// header fields
	logic [3:0]  ihl;
	logic [5:0]  hdr_b;
	logic [15:0] hdr16;
	logic [15:0] tot;
	logic [15:0] br16;
	logic [15:0] tot_m1;

	always_comb begin
		ihl    = hdr0_q[59:56];
		hdr_b  = {ihl, 2'b00};
		hdr16  = 16'(hdr_b);
		tot    = hdr0_q[47:32];
		br16   = 16'(br_q);
		tot_m1 = tot - 16'd1;
	end

	// per-lane checksum contributions of the word read
	logic [7:0]  ip_b   [8];
	logic [7:0]  icmp_b [8];
	logic [17:0] ip_add, icmp_add;
	logic [15:0] bi;

	always_comb begin
		ip_add   = '0;
		icmp_add = '0;
		bi       = '0;
		for (int j = 0; j < 8; j++) begin
			bi = 16'({addr_s1, 3'(j)});
			ip_b[j] = ((bi < hdr16) && (bi != IP_CSUM_HI) && (bi != IP_CSUM_LO)) ?
				rdata_s1[63 - 8 * j -: 8] : 8'd0;
			icmp_b[j] = ((bi > hdr16) && (bi < tot) && (bi != hdr16 + 16'd2) &&
				(bi != hdr16 + 16'd3)) ? rdata_s1[63 - 8 * j -: 8] : 8'd0;
		end
		for (int l = 0; l < 4; l++) begin
			ip_add   = ip_add + 18'({ip_b[2 * l], ip_b[2 * l + 1]});
			icmp_add = icmp_add + 18'({icmp_b[2 * l], icmp_b[2 * l + 1]});
		end
	end

	// reply word built from the read data
	logic [63:0] ow;
	logic [15:0] rem;
	logic [3:0]  ocnt;
	logic        olast;
	logic [15:0] obi;

	always_comb begin
		ow  = rdata_s1;
		obi = '0;
		if (addr_s1 == AW'(1)) begin
			ow[47:32] = ip_csum_q;
			ow[31:0]  = hdr2_q[63:32];
		end
		if (addr_s1 == AW'(2)) begin
			ow[63:32] = hdr1_q[31:0];
		end
		for (int j = 0; j < 8; j++) begin
			obi = 16'({addr_s1, 3'(j)});
			if (obi == hdr16) begin
				ow[63 - 8 * j -: 8] = ICMP_ECHO_REP;
			end else if (obi == hdr16 + 16'd2) begin
				ow[63 - 8 * j -: 8] = icmp_csum_q[15:8];
			end else if (obi == hdr16 + 16'd3) begin
				ow[63 - 8 * j -: 8] = icmp_csum_q[7:0];
			end
		end
		rem   = tot - 16'({addr_s1, 3'b000});
		ocnt  = (rem >= 16'd8) ? 4'd8 : rem[3:0];
		olast = rem <= 16'd8;
		ow    = ow & top_mask(ocnt);
	end

	// packet store: written while packing, read for the two passes
	always_ff @(posedge clk) begin
		if (wen) begin
			pkt_mem_q[wr_addr_w[AW-1:0]] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= pkt_mem_q[wcnt_q];
			addr_s1  <= wcnt_q;
		end
	end

	// header words kept as they are written, packing remainder, icmp type, checksums and output word
	always_ff @(posedge clk) begin
		if (wen && wr_addr_w == (AW + 1)'(0)) begin
			hdr0_q <= wdata;
		end
		if (wen && wr_addr_w == (AW + 1)'(1)) begin
			hdr1_q <= wdata;
		end
		if (wen && wr_addr_w == (AW + 1)'(2)) begin
			hdr2_q <= wdata;
		end
		if (cmd.store) begin
			acc_q <= spill ? remainder : combined;
		end
		if (rvld_s1 && sum_s1 && addr_s1 == AW'(hdr_b[5:3])) begin
			type_q <= hdr_b[2] ? rdata_s1[31:24] : rdata_s1[63:56];
		end
		if (cmd.fold) begin
			ip_csum_q   <= fold_csum(ip_acc_q);
			icmp_csum_q <= fold_csum(icmp_acc_q);
		end
		if (cmd.load_out) begin
			out_word_q <= ow;
			out_cnt_q  <= ocnt;
			out_last_q <= olast;
		end
	end

	// byte count, overflow flag, pass counter, read flags, sums and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			br_q        <= '0;
			ov_q        <= 1'b0;
			wcnt_q      <= '0;
			rvld_s1     <= 1'b0;
			sum_s1      <= 1'b0;
			ip_acc_q    <= '0;
			icmp_acc_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.end_pkt) begin
				br_q <= '0;
				ov_q <= 1'b0;
			end else if (cmd.store) begin
				br_q <= br_q + CW'(eff);
				ov_q <= ov_q | ovf_now;
			end
			rvld_s1 <= cmd.rd_en;
			sum_s1  <= cmd.rd_sum;
			if (cmd.clr_pass) begin
				wcnt_q     <= '0;
				ip_acc_q   <= '0;
				icmp_acc_q <= '0;
			end else begin
				if (cmd.rd_en) begin
					wcnt_q <= wcnt_q + AW'(1);
				end
				if (rvld_s1 && sum_s1) begin
					ip_acc_q   <= ip_acc_q + SW'(ip_add);
					icmp_acc_q <= icmp_acc_q + SW'(icmp_add);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// status back to the controller
	always_comb begin
		stat.pre_ok = !ov_q && (br16 >= MIN_HDR_BYTES) && (hdr0_q[63:60] == IP_VERSION_4) &&
			(hdr1_q[55:48] == PROTO_ICMP) && (ihl >= MIN_IHL) && (tot <= br16) &&
			(tot >= hdr16 + 16'd4);
		stat.pass_end  = wcnt_q == tot_m1[AW+2:3];
		stat.type_ok   = type_q == ICMP_ECHO_REQ;
		stat.out_taken = out_valid_q && !out_stall;
		stat.out_last  = out_last_q;
	end

	assign out_valid      = out_valid_q;
	assign out_word       = out_word_q;
	assign out_byte_count = out_cnt_q;
	assign out_last       = out_last_q;

endmodule

`default_nettype wire

FILE: src/ier_ctrl.sv
// ier_ctrl: sequencer for packing, header check, checksum pass and reply output
// depends on ier_pkg
`default_nettype none

module ier_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_last,
	output logic                    in_stall,
	input  wire ier_pkg::ier_stat_t stat,
	output ier_pkg::ier_cmd_t       cmd
);
	import ier_pkg::*;

	typedef enum logic [3:0] {
		S_COLLECT,
		S_FLUSH,
		S_CHECK,
		S_SUM_RD,
		S_SUM_WAIT,
		S_FOLD,
		S_OUT_RD,
		S_OUT_LD,
		S_OUT_HOLD
	} state_t;

	state_t state_q;
	state_t state_d;

	// input words only while collecting
	assign in_stall = (state_q != S_COLLECT);

	// next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_COLLECT: begin
				cmd.store = in_valid;
				if (in_valid && in_last) begin
					state_d = S_FLUSH;
				end
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (stat.pre_ok) begin
					cmd.clr_pass = 1'b1;
					state_d      = S_SUM_RD;
				end else begin
					cmd.end_pkt = 1'b1;
					state_d     = S_COLLECT;
				end
			end
			S_SUM_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sum = 1'b1;
				if (stat.pass_end) begin
					state_d = S_SUM_WAIT;
				end
			end
			S_SUM_WAIT: begin
				state_d = S_FOLD;
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (stat.type_ok) begin
					cmd.clr_pass = 1'b1;
					state_d      = S_OUT_RD;
				end else begin
					cmd.end_pkt = 1'b1;
					state_d     = S_COLLECT;
				end
			end
			S_OUT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_OUT_LD;
			end
			S_OUT_LD: begin
				cmd.load_out = 1'b1;
				state_d      = S_OUT_HOLD;
			end
			S_OUT_HOLD: begin
				if (stat.out_taken) begin
					if (stat.out_last) begin
						cmd.end_pkt = 1'b1;
						state_d     = S_COLLECT;
					end else begin
						state_d = S_OUT_RD;
					end
				end
			end
			default: begin
				state_d = S_COLLECT;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: src/icmp_echo_responder.sv
// icmp_echo_responder: top level of the ipv4 icmp echo responder
// depends on ier_pkg, ier_ctrl and ier_datapath
//
// usage
//   input channel (in_valid/in_stall): raw ipv4 packet, one word of up to eight bytes
//   per handshake, first byte in bits 63:56, in_last on the final word. words are
//   taken one per cycle while a packet is collected.
//   output channel (out_valid/out_stall): the echo reply, tot_len bytes, one word per
//   handshake, unused low bytes zero, out_last on the final word.
// sequence
//   after the last input word: the partial word is written, the header is checked, the
//   checksum read pass runs over the packet store and the sums are folded, then each
//   reply word is read from the store, loaded and handed over, the hand over waiting
//   while the receiver stalls. input is stalled from the last word until the reply has
//   gone out or the packet has been dropped (at the header check for a bad header).
//   packets that are not echo requests, or are malformed or too long, give no words.
// reset
//   arst_n clears the byte count and the sequencer; the store needs no clearing and
//   words are accepted straight away. a stalled output word is held unchanged.
`default_nettype none

module icmp_echo_responder #(
	parameter int MAX_PACKET_BYTES = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] in_word,
	input  wire logic [3:0]  in_byte_count,
	input  wire logic        in_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      out_word,
	output logic [3:0]       out_byte_count,
	output logic             out_last
);
	import ier_pkg::*;

	ier_cmd_t  cmd;
	ier_stat_t stat;

	// sequencer
	ier_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_last  (in_last),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, checks, checksums and output register
	ier_datapath #(
		.MAX_PACKET_BYTES (MAX_PACKET_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_word        (in_word),
		.in_byte_count  (in_byte_count),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.out_word       (out_word),
		.out_byte_count (out_byte_count),
		.out_last       (out_last)
	);

endmodule

`default_nettype wire
